// ===== sv/bts_pkg.sv =====
// Shared types, constants and the gamma lookup table for the bilinear texture sampler.
// No dependencies; the top, front and back files import this package, bts_fifo does not.
`default_nettype none

package bts_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CMD_DEPTH      = 2;
  localparam int OUT_DEPTH      = 2;

  // field widths of the command word, sized for the largest allowed texture
  localparam int COORD_W = 12;
  localparam int ADDR_W  = 24;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_HAS_ALPHA = 2'd2;

  typedef struct packed {
    logic        func;
    logic [15:0] texel_index;
    logic [7:0]  src_byte0;
    logic [7:0]  src_byte1;
    logic [7:0]  src_byte2;
    logic [7:0]  src_byte3;
    logic [15:0] coord_u;
    logic [15:0] coord_v;
  } in_t;

  typedef struct packed {
    logic [7:0] lane0;
    logic [7:0] lane1;
    logic [7:0] lane2;
    logic [7:0] lane3;
  } out_t;

  typedef struct packed {
    logic               is_sample;
    logic [ADDR_W-1:0]  addr;
    logic [31:0]        data;
    logic [COORD_W-1:0] ix;
    logic [COORD_W-1:0] ix1;
    logic [ADDR_W-1:0]  row0;
    logic [ADDR_W-1:0]  row1;
    logic [15:0]        fx;
    logic [15:0]        fy;
  } cmd_t;

  typedef logic [7:0] gamma_tab_t [256];

  // largest y with y^11 <= b^5 * 255^6, i.e. floor(255*(b/255)^(1/2.2))
  function automatic gamma_tab_t build_gamma();
    gamma_tab_t   t;
    logic [127:0] rhs;
    logic [127:0] lhs;
    int           y;
    y = 0;
    for (int b = 0; b < 256; b++) begin
      rhs = 128'd1;
      for (int k = 0; k < 5; k++) rhs = rhs * 128'(b);
      for (int k = 0; k < 6; k++) rhs = rhs * 128'd255;
      while (y < 255) begin
        lhs = 128'd1;
        for (int k = 0; k < 11; k++) lhs = lhs * 128'(y + 1);
        if (lhs > rhs) break;
        y++;
      end
      t[b] = 8'(y);
    end
    return t;
  endfunction

  localparam gamma_tab_t GAMMA = build_gamma();

endpackage

`default_nettype wire

// ===== sv/bilinear_texture_sampler_top.sv =====
// Writes: two front stages, then the memory write in the back; one write per cycle
// sustained while the back end is idle. Samples: the back end takes no new sample until
// the last one is done: four reads share the single read port of the texel memory.
// Reset (synchronous, rst high) empties both queues and the pipelines and sets
// width 256, height 256, alpha present. Texel memory is not cleared.
`default_nettype none

module bilinear_texture_sampler_top import bts_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire in_t        in_word,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output out_t            out_word,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_addr,
  input  wire logic [8:0] cfg_data
);

  logic [8:0] image_width;
  logic [8:0] image_height;
  logic       source_has_alpha;

  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic out_push;
  logic out_full;
  out_t res_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= 9'd256;
      image_height     <= 9'd256;
      source_has_alpha <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_WIDTH:     image_width      <= cfg_data;
        REG_HEIGHT:    image_height     <= cfg_data;
        REG_HAS_ALPHA: source_has_alpha <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  bts_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst, .push, .in_word, .full,
    .image_width, .image_height, .source_has_alpha,
    .cmd_push, .cmd(cmd_in), .cmd_full
  );

  bts_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk, .rst, .push(cmd_push), .din(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .dout(cmd_out), .empty(cmd_empty)
  );

  bts_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk, .rst, .cmd(cmd_out), .cmd_empty, .cmd_pop,
    .out_full, .out_push, .out_word(res_word)
  );

  bts_fifo #(.WIDTH($bits(out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk, .rst, .push(out_push), .din(res_word), .full(out_full),
    .pop, .dout(out_word), .empty
  );

  a_cmd_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_push && cmd_full)) else $error("command queue overflow");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(out_push && out_full)) else $error("result queue overflow");

  a_cmd_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(cmd_pop && cmd_empty)) else $error("command queue underflow");

endmodule

`default_nettype wire

// ===== sv/bts_fifo.sv =====
// Small synchronous queue used between front and back and on the result side.
// Depends on nothing; depth must be a power of two.
`default_nettype none

module bts_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

endmodule

`default_nettype wire

// ===== sv/bts_front.sv =====
// Front end: accepts items, gamma-lifts written texels, maps sample coordinates
// to texel positions and row bases. Depends on bts_pkg.
`default_nettype none

module bts_front import bts_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire in_t        in_word,
  output logic            full,
  input  wire logic [8:0] image_width,
  input  wire logic [8:0] image_height,
  input  wire logic       source_has_alpha,
  output logic            cmd_push,
  output cmd_t            cmd,
  input  wire logic       cmd_full
);

  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int RW    = XW + YW;

  logic          adv;
  logic          accept;
  logic [DW-1:0] w;
  logic [HW-1:0] h;
  logic          in_range;
  logic [31:0]   texel;

  // stage 1
  logic                s1_valid;
  logic                s1_sample;
  logic [ADDR_W-1:0]   s1_addr;
  logic [31:0]         s1_data;
  logic [16+DW-1:0]    s1_px;
  logic [17+HW-1:0]    s1_py;

  // stage 1 decode
  logic [DW-1:0] ixr;
  logic [HW:0]   iyr;
  logic [XW-1:0] ix;
  logic [XW-1:0] ix1;
  logic [YW-1:0] iy;
  logic [YW-1:0] iy1;
  logic [15:0]   fx;
  logic [15:0]   fy;

  // stage 2
  logic s2_valid;
  cmd_t s2;

  always_comb begin
    if (image_width == '0)                     w = DW'(1);
    else if (32'(image_width) > MAX_WIDTH)     w = DW'(MAX_WIDTH);
    else                                       w = DW'(image_width);
    if (image_height == '0)                    h = HW'(1);
    else if (32'(image_height) > MAX_HEIGHT)   h = HW'(MAX_HEIGHT);
    else                                       h = HW'(image_height);
  end

  assign adv      = !s2_valid || !cmd_full;
  assign full     = !adv;
  assign accept   = push && adv;
  assign in_range = 32'(in_word.texel_index) < DEPTH;
  assign texel    = {source_has_alpha ? GAMMA[in_word.src_byte3] : 8'hFF,
                     GAMMA[in_word.src_byte0],
                     GAMMA[in_word.src_byte1],
                     GAMMA[in_word.src_byte2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && (in_word.func == FUNC_SAMPLE || in_range);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sample <= (in_word.func == FUNC_SAMPLE);
      s1_addr   <= ADDR_W'(in_word.texel_index);
      s1_data   <= texel;
      s1_px     <= (16+DW)'(in_word.coord_u) * (16+DW)'(w);
      s1_py     <= ((17+HW)'(17'h10000) - (17+HW)'(in_word.coord_v)) * (17+HW)'(h);
    end
  end

  // far edge clamp and neighbor selection
  always_comb begin
    ixr = s1_px[16 +: DW];
    iyr = s1_py[16 +: HW+1];
    if (32'(ixr) >= 32'(w)) begin
      ix = XW'(w - 1'b1);
      fx = '0;
    end else begin
      ix = XW'(ixr);
      fx = s1_px[15:0];
    end
    if (32'(iyr) >= 32'(h)) begin
      iy = YW'(h - 1'b1);
      fy = '0;
    end else begin
      iy = YW'(iyr);
      fy = s1_py[15:0];
    end
    ix1 = (32'(ix) == 32'(w) - 1) ? ix : ix + 1'b1;
    iy1 = (32'(iy) == 32'(h) - 1) ? iy : iy + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.is_sample <= s1_sample;
      s2.addr      <= s1_addr;
      s2.data      <= s1_data;
      s2.ix        <= COORD_W'(ix);
      s2.ix1       <= COORD_W'(ix1);
      s2.row0      <= ADDR_W'(RW'(iy) * RW'(w));
      s2.row1      <= ADDR_W'(RW'(iy1) * RW'(w));
      s2.fx        <= fx;
      s2.fy        <= fy;
    end
  end

  assign cmd_push = s2_valid && !cmd_full;
  assign cmd      = s2;

endmodule

`default_nettype wire

// ===== sv/bts_back.sv =====
// Back end: texel memory, four-read sequencer and two-level bilinear blend.
// Depends on bts_pkg.
`default_nettype none

module bts_back import bts_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  input  wire logic out_full,
  output logic      out_push,
  output out_t      out_word
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_READ     = 5'b00010,
    ST_WAIT     = 5'b00100,
    ST_LERP_IN  = 5'b01000,
    ST_LERP_OUT = 5'b10000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [1:0]  cnt;
  cmd_t        cur;
  logic [31:0] mem [DEPTH];
  logic [31:0] mem_q;
  logic [31:0] tex [4];
  logic [23:0] top [4];
  logic [23:0] bot [4];
  logic [AW-1:0] rd_addr;
  logic [7:0]  res [4];
  logic        start_write;
  logic        start_sample;

  function automatic logic [23:0] lerp_in(input logic [7:0] a, input logic [7:0] b,
                                          input logic [15:0] f);
    logic signed [25:0] d;
    logic signed [25:0] s;
    d = 26'($signed({1'b0, b}) - $signed({1'b0, a}));
    s = $signed({2'b00, a, 16'h0000}) + d * $signed({10'b0, f});
    return s[23:0];
  endfunction

  function automatic logic [7:0] lerp_out(input logic [23:0] t, input logic [23:0] bt,
                                          input logic [15:0] f);
    logic signed [41:0] d;
    logic signed [41:0] s;
    d = 42'($signed({1'b0, bt}) - $signed({1'b0, t}));
    s = $signed({2'b00, t, 16'h0000}) + d * $signed({26'b0, f});
    return s[39:32];
  endfunction

  assign start_write  = (state == ST_IDLE) && !cmd_empty && !cmd.is_sample;
  assign start_sample = (state == ST_IDLE) && !cmd_empty && cmd.is_sample && !out_full;
  assign cmd_pop      = start_write || start_sample;

  // neighbor order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
  always_comb begin
    case (cnt)
      2'd0:    rd_addr = AW'(cur.row0) + AW'(cur.ix);
      2'd1:    rd_addr = AW'(cur.row0) + AW'(cur.ix1);
      2'd2:    rd_addr = AW'(cur.row1) + AW'(cur.ix);
      default: rd_addr = AW'(cur.row1) + AW'(cur.ix1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (start_write) mem[AW'(cmd.addr)] <= cmd.data;
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (start_sample) state_next = ST_READ;
      ST_READ:     if (cnt == 2'd3) state_next = ST_WAIT;
      ST_WAIT:     state_next = ST_LERP_IN;
      ST_LERP_IN:  state_next = ST_LERP_OUT;
      ST_LERP_OUT: state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_READ) cnt <= cnt + 1'b1;
      else                  cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_sample) cur <= cmd;
    // read data arrives in the cycle after its address
    if ((state == ST_READ && cnt != 2'd0) || state == ST_WAIT) begin
      for (int i = 0; i < 3; i++) tex[i] <= tex[i+1];
      tex[3] <= mem_q;
    end
    if (state == ST_LERP_IN) begin
      for (int k = 0; k < 4; k++) begin
        top[k] <= lerp_in(tex[0][8*k +: 8], tex[1][8*k +: 8], cur.fx);
        bot[k] <= lerp_in(tex[2][8*k +: 8], tex[3][8*k +: 8], cur.fx);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) res[k] = lerp_out(top[k], bot[k], cur.fy);
  end

  assign out_push       = (state == ST_LERP_OUT);
  assign out_word.lane0 = res[0];
  assign out_word.lane1 = res[1];
  assign out_word.lane2 = res[2];
  assign out_word.lane3 = res[3];

endmodule

`default_nettype wire
